FILE: sv/mdtt_pkg.sv
// mdtt_pkg: types and constants shared by the deadline timer table modules.
// Holds the command/response transaction structs, controller states and the
// controller-to-datapath command and status structs. No dependencies.
package mdtt_pkg;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_EXPIRE = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        RS_OK        = 2'd0,
        RS_NO_SLOT   = 2'd1,
        RS_NOT_FOUND = 2'd2
    } status_t;

    localparam logic [31:0] ID_NONE  = 32'hFFFF_FFFF;
    localparam logic [30:0] WAIT_CAP = 31'h7FFF_FFFF;

    typedef struct packed {
        action_t            action;
        logic [47:0]        now_ms;
        logic [30:0]        period_ms;
        logic               repeat_req;
        logic [31:0]        timer_id;
        logic signed [31:0] max_wait_ms;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [31:0]        result_id;
        logic               fired;
        logic signed [31:0] wait_ms;
        logic [6:0]         live_count;
        logic               last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_CANCEL_SCAN,
        S_EXPIRE_SCAN,
        S_FIRE_SCAN,
        S_QUERY_SCAN,
        S_QUERY_CAP,
        S_QUERY_CLAMP,
        S_REPLY
    } state_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic latch;
        logic clr_idx;
        logic inc_idx;
        logic add_step;
        logic cancel_step;
        logic expire_step;
        logic query_step;
        logic query_cap;
        logic query_clamp;
        logic emit_reply;
        logic emit_fire;
        logic emit_empty;
    } ctl_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic scan_last;
        logic add_hit;
        logic cancel_hit;
        logic due_any;
        logic due_cur;
        logic due_last;
        logic out_free;
    } stat_t;

endpackage

FILE: sv/mdtt_ctrl.sv
// mdtt_ctrl: sequencer for the deadline timer table.
// Walks the slot scans for each action and issues datapath commands.
// Depends on mdtt_pkg.
module mdtt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  mdtt_pkg::action_t   action,
    input  mdtt_pkg::stat_t     stat,
    output logic                cmd_stall,
    output mdtt_pkg::ctl_t      ctl
);

    mdtt_pkg::state_t state_reg;
    mdtt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mdtt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mdtt_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (action)
                        mdtt_pkg::ACT_ADD:    state_next = mdtt_pkg::S_ADD_SCAN;
                        mdtt_pkg::ACT_CANCEL: state_next = mdtt_pkg::S_CANCEL_SCAN;
                        mdtt_pkg::ACT_EXPIRE: state_next = mdtt_pkg::S_EXPIRE_SCAN;
                        mdtt_pkg::ACT_QUERY:  state_next = mdtt_pkg::S_QUERY_SCAN;
                        default:              state_next = mdtt_pkg::S_IDLE;
                    endcase
                end
            end
            mdtt_pkg::S_ADD_SCAN:
            begin
                if (stat.add_hit || stat.scan_last)
                begin
                    state_next = mdtt_pkg::S_REPLY;
                end
            end
            mdtt_pkg::S_CANCEL_SCAN:
            begin
                if (stat.cancel_hit || stat.scan_last)
                begin
                    state_next = mdtt_pkg::S_REPLY;
                end
            end
            mdtt_pkg::S_EXPIRE_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = mdtt_pkg::S_FIRE_SCAN;
                end
            end
            mdtt_pkg::S_FIRE_SCAN:
            begin
                if (!stat.due_any)
                begin
                    if (stat.out_free)
                    begin
                        state_next = mdtt_pkg::S_IDLE;
                    end
                end
                else if (stat.due_cur && stat.due_last && stat.out_free)
                begin
                    state_next = mdtt_pkg::S_IDLE;
                end
            end
            mdtt_pkg::S_QUERY_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = mdtt_pkg::S_QUERY_CAP;
                end
            end
            mdtt_pkg::S_QUERY_CAP:   state_next = mdtt_pkg::S_QUERY_CLAMP;
            mdtt_pkg::S_QUERY_CLAMP: state_next = mdtt_pkg::S_REPLY;
            mdtt_pkg::S_REPLY:
            begin
                if (stat.out_free)
                begin
                    state_next = mdtt_pkg::S_IDLE;
                end
            end
            default: state_next = mdtt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        cmd_stall = 1'b1;
        unique case (state_reg)
            mdtt_pkg::S_IDLE:
            begin
                cmd_stall   = 1'b0;
                ctl.latch   = cmd_valid;
                ctl.clr_idx = cmd_valid;
            end
            mdtt_pkg::S_ADD_SCAN:
            begin
                ctl.add_step = 1'b1;
                ctl.inc_idx  = !stat.add_hit && !stat.scan_last;
            end
            mdtt_pkg::S_CANCEL_SCAN:
            begin
                ctl.cancel_step = 1'b1;
                ctl.inc_idx     = !stat.cancel_hit && !stat.scan_last;
            end
            mdtt_pkg::S_EXPIRE_SCAN:
            begin
                ctl.expire_step = 1'b1;
                ctl.clr_idx     = stat.scan_last;
                ctl.inc_idx     = !stat.scan_last;
            end
            mdtt_pkg::S_FIRE_SCAN:
            begin
                if (!stat.due_any)
                begin
                    ctl.emit_empty = stat.out_free;
                end
                else if (stat.due_cur)
                begin
                    ctl.emit_fire = stat.out_free;
                    ctl.inc_idx   = stat.out_free && !stat.due_last;
                end
                else
                begin
                    // skip slots that did not fire
                    ctl.inc_idx = 1'b1;
                end
            end
            mdtt_pkg::S_QUERY_SCAN:
            begin
                ctl.query_step = 1'b1;
                ctl.inc_idx    = !stat.scan_last;
            end
            mdtt_pkg::S_QUERY_CAP:   ctl.query_cap   = 1'b1;
            mdtt_pkg::S_QUERY_CLAMP: ctl.query_clamp = 1'b1;
            mdtt_pkg::S_REPLY:       ctl.emit_reply  = stat.out_free;
            default:                 ctl             = '0;
        endcase
    end

endmodule

FILE: sv/mdtt_dpath.sv
// mdtt_dpath: slot storage, scan index, result registers and response register.
// Executes one controller command per cycle on the slot indexed by the scan.
// Depends on mdtt_pkg.
module mdtt_dpath #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mdtt_pkg::cmd_t  cmd,
    input  mdtt_pkg::ctl_t  ctl,
    input  logic            rsp_stall,
    output mdtt_pkg::stat_t stat,
    output logic            rsp_valid,
    output mdtt_pkg::rsp_t  rsp
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMER_SLOTS - 1);

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [30:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {18'd0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    // slot storage
    logic [TIMER_SLOTS-1:0] active_reg, active_next;
    logic [31:0]            slot_id_reg       [TIMER_SLOTS];
    logic [47:0]            slot_deadline_reg [TIMER_SLOTS];
    logic [30:0]            slot_interval_reg [TIMER_SLOTS];
    logic                   slot_periodic_reg [TIMER_SLOTS];

    logic [6:0]             count_reg, count_next;
    logic [31:0]            next_id_reg, next_id_next;
    logic [TIMER_SLOTS-1:0] due_reg, due_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    mdtt_pkg::cmd_t         cmd_reg;
    mdtt_pkg::status_t      res_status_reg;
    logic [31:0]            res_id_reg;
    logic signed [31:0]     res_wait_reg;
    logic [47:0]            min_reg;
    logic [30:0]            wait_cap_reg;
    mdtt_pkg::rsp_t         rsp_reg;

    logic [TIMER_SLOTS-1:0] idx_onehot;
    logic                   cur_active;
    logic [31:0]            cur_id;
    logic [47:0]            cur_deadline;
    logic [30:0]            cur_interval;
    logic                   cur_periodic;
    logic                   cur_due;
    logic                   add_hit;
    logic                   cancel_hit;
    logic                   out_free;
    logic [48:0]            diff;

    always_comb
    begin
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            idx_onehot[i] = (IDX_W'(i) == idx_reg);
        end
    end

    assign cur_active   = active_reg[idx_reg];
    assign cur_id       = slot_id_reg[idx_reg];
    assign cur_deadline = slot_deadline_reg[idx_reg];
    assign cur_interval = slot_interval_reg[idx_reg];
    assign cur_periodic = slot_periodic_reg[idx_reg];
    assign cur_due      = cur_active && (cur_deadline <= cmd_reg.now_ms);
    assign add_hit      = !cur_active;
    assign cancel_hit   = cur_active && (cur_id == cmd_reg.timer_id)
                          && (cmd_reg.timer_id != mdtt_pkg::ID_NONE);
    assign out_free     = !rsp_valid_reg || !rsp_stall;
    assign diff         = {1'b0, min_reg} - {1'b0, cmd_reg.now_ms};

    always_comb
    begin
        stat.scan_last  = (idx_reg == IDX_LAST);
        stat.add_hit    = add_hit;
        stat.cancel_hit = cancel_hit;
        stat.due_any    = |due_reg;
        stat.due_cur    = due_reg[idx_reg];
        stat.due_last   = ((due_reg & ~idx_onehot) == '0);
        stat.out_free   = out_free;
    end

    // control state next values
    always_comb
    begin
        active_next    = active_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        due_next       = due_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (ctl.clr_idx)
        begin
            idx_next = '0;
        end
        else if (ctl.inc_idx)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (ctl.latch)
        begin
            due_next   = '0;
            found_next = 1'b0;
        end

        if (ctl.add_step && add_hit)
        begin
            active_next  = active_reg | idx_onehot;
            count_next   = count_reg + 7'd1;
            next_id_next = next_id_reg + 32'd1;
        end

        if (ctl.cancel_step && cancel_hit)
        begin
            active_next = active_reg & ~idx_onehot;
            count_next  = count_reg - 7'd1;
        end

        if (ctl.expire_step && cur_due)
        begin
            due_next = due_reg | idx_onehot;
            if (!cur_periodic)
            begin
                active_next = active_reg & ~idx_onehot;
                count_next  = count_reg - 7'd1;
            end
        end

        if (ctl.query_step && cur_active)
        begin
            found_next = 1'b1;
        end

        if (ctl.emit_fire)
        begin
            due_next = due_reg & ~idx_onehot;
        end

        if (ctl.emit_reply || ctl.emit_fire || ctl.emit_empty)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            count_reg     <= '0;
            next_id_reg   <= '0;
            due_reg       <= '0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            due_reg       <= due_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // slot payload writes: fill on add, rearm a periodic timer on expire
    always_ff @(posedge clk)
    begin
        if (ctl.add_step && add_hit)
        begin
            slot_id_reg[idx_reg]       <= next_id_reg;
            slot_deadline_reg[idx_reg] <= sat_add(cmd_reg.now_ms, cmd_reg.period_ms);
            slot_interval_reg[idx_reg] <= cmd_reg.period_ms;
            slot_periodic_reg[idx_reg] <= cmd_reg.repeat_req;
        end
        else if (ctl.expire_step && cur_due && cur_periodic)
        begin
            slot_deadline_reg[idx_reg] <= sat_add(cmd_reg.now_ms, cur_interval);
        end
    end

    // transaction payload and result registers
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg        <= cmd;
            res_status_reg <= mdtt_pkg::RS_OK;
            res_id_reg     <= '0;
            res_wait_reg   <= '0;
        end

        if (ctl.add_step)
        begin
            if (add_hit)
            begin
                res_status_reg <= mdtt_pkg::RS_OK;
                res_id_reg     <= next_id_reg;
            end
            else
            begin
                res_status_reg <= mdtt_pkg::RS_NO_SLOT;
            end
        end

        if (ctl.cancel_step)
        begin
            res_status_reg <= cancel_hit ? mdtt_pkg::RS_OK : mdtt_pkg::RS_NOT_FOUND;
        end

        if (ctl.query_step && cur_active && (!found_reg || (cur_deadline < min_reg)))
        begin
            min_reg <= cur_deadline;
        end

        if (ctl.query_cap)
        begin
            if (diff[48])
            begin
                wait_cap_reg <= '0;
            end
            else if (|diff[47:31])
            begin
                wait_cap_reg <= mdtt_pkg::WAIT_CAP;
            end
            else
            begin
                wait_cap_reg <= diff[30:0];
            end
        end

        if (ctl.query_clamp)
        begin
            if (!found_reg)
            begin
                res_wait_reg <= cmd_reg.max_wait_ms;
            end
            else if (!cmd_reg.max_wait_ms[31] && (wait_cap_reg > cmd_reg.max_wait_ms[30:0]))
            begin
                res_wait_reg <= cmd_reg.max_wait_ms;
            end
            else
            begin
                res_wait_reg <= signed'({1'b0, wait_cap_reg});
            end
        end

        if (ctl.emit_reply)
        begin
            rsp_reg.status     <= res_status_reg;
            rsp_reg.result_id  <= res_id_reg;
            rsp_reg.fired      <= 1'b0;
            rsp_reg.wait_ms    <= res_wait_reg;
            rsp_reg.live_count <= count_reg;
            rsp_reg.last       <= 1'b1;
        end
        else if (ctl.emit_fire)
        begin
            rsp_reg.status     <= mdtt_pkg::RS_OK;
            rsp_reg.result_id  <= cur_id;
            rsp_reg.fired      <= 1'b1;
            rsp_reg.wait_ms    <= '0;
            rsp_reg.live_count <= count_reg;
            rsp_reg.last       <= stat.due_last;
        end
        else if (ctl.emit_empty)
        begin
            rsp_reg.status     <= mdtt_pkg::RS_OK;
            rsp_reg.result_id  <= '0;
            rsp_reg.fired      <= 1'b0;
            rsp_reg.wait_ms    <= '0;
            rsp_reg.live_count <= count_reg;
            rsp_reg.last       <= 1'b1;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/multi_slot_deadline_timer_table.sv
// multi_slot_deadline_timer_table: top level of the timer slot table.
// Joins the sequencer (mdtt_ctrl) and the slot datapath (mdtt_dpath).
// Depends on mdtt_pkg, mdtt_ctrl, mdtt_dpath.
//
//   channel | direction | payload          | handshake
//   --------+-----------+------------------+---------------------------
//   cmd     | in        | mdtt_pkg::cmd_t  | cmd_valid / cmd_stall
//   rsp     | out       | mdtt_pkg::rsp_t  | rsp_valid / rsp_stall
//
// Scans: one transaction at a time; each action walks the slots one per
//   cycle, holding at an emit step while the output register is busy. Add
//   and cancel stop at a hit or the last slot, query scans all slots, and
//   expire scans all, then emits a result per fired slot, stopping at the last.
// Reset: rst_n clears the active marks, active count, id counter, due marks,
//   scan index and response valid; slot contents are not reset.
// Stalls: the response sits in an output register; a new command is taken
//   while an earlier response waits, and the sequencer holds at each emit
//   step until the output register is free.
module multi_slot_deadline_timer_table #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  mdtt_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mdtt_pkg::rsp_t rsp
);

    mdtt_pkg::ctl_t  ctl;
    mdtt_pkg::stat_t stat;

    // sequencer: one state per scan pass, plus the query cap, clamp and reply steps
    mdtt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .action    (cmd.action),
        .stat      (stat),
        .cmd_stall (cmd_stall),
        .ctl       (ctl)
    );

    // datapath: slot storage, scan index and response register
    mdtt_dpath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

FILE: sv/mdtt_checker.sv
// mdtt_checker: port-level checks for the timer slot table, bound to the top.
// Sees only the top-level ports. Depends on mdtt_pkg.
module mdtt_checker #(
    parameter int TIMER_SLOTS = 16
) (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_stall,
    input mdtt_pkg::cmd_t cmd,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input mdtt_pkg::rsp_t rsp
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // block goes busy after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken while previous one still in progress");

    // a full table is the only reason for a failed add
    a_no_slot_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == mdtt_pkg::RS_NO_SLOT)
        |-> (rsp.live_count == 7'(TIMER_SLOTS)) && !rsp.fired)
        else $error("no-slot status with free slots");

    // fired results carry ok status and no wait value
    a_fired_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.fired |-> (rsp.status == mdtt_pkg::RS_OK) && (rsp.wait_ms == 0))
        else $error("malformed fired result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.live_count <= 7'(TIMER_SLOTS))
        else $error("active count above slot count");

endmodule

bind multi_slot_deadline_timer_table mdtt_checker #(
    .TIMER_SLOTS (TIMER_SLOTS)
) u_mdtt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
